### sv/gregorian_days_between_core_defines.svh
// ----------------------------------------------------------------------------
// gregorian_days_between_core_defines
// Assertion macros used by the checker file of the date difference core.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAYS_BETWEEN_CORE_DEFINES_SVH
`define GREGORIAN_DAYS_BETWEEN_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define GDB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gdb assertion failed");

// next-cycle implication, off while reset is asserted
`define GDB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gdb assertion failed");

`endif

### sv/gdb_pkg.sv
// ----------------------------------------------------------------------------
// gdb_pkg
// Types, constants and tables for the Gregorian date difference core.
// ----------------------------------------------------------------------------
package gdb_pkg;

    localparam int YEAR_W  = 14;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int SER_W   = 23;
    localparam int COUNT_W = 22;
    localparam int QCEN_W  = 8;
    localparam int OFS_W   = 9;
    localparam int PROD_W  = 29;
    localparam int RECIP_SHIFT = 21;

    localparam logic [PROD_W-1:0]  RECIP_100   = PROD_W'(20972);
    localparam logic [YEAR_W-1:0]  HUNDRED     = YEAR_W'(100);
    localparam logic [YEAR_W:0]    YEAR_OFS    = (YEAR_W+1)'(399);
    localparam logic [QCEN_W-1:0]  CENT_OFS    = QCEN_W'(3);
    localparam logic [SER_W-1:0]   DAYS_YEAR   = SER_W'(365);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    function automatic logic [OFS_W-1:0] days_before(input logic [MON_W-1:0] mon);
        logic [OFS_W-1:0] d;
        unique case (mon)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### sv/gregorian_days_between_core.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_core
// Days from a start date to an end date, proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not stalled; the per-date
// serial pipeline is 4 stages followed by one compare/subtract output stage.
// Reset: synchronous active low, clears all stage valid bits; payload is not reset.
module gregorian_days_between_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [gdb_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [gdb_pkg::MON_W-1:0]      i_start_month,
    input  logic [gdb_pkg::DAY_W-1:0]      i_start_day,
    input  logic [gdb_pkg::YEAR_W-1:0]     i_end_year,
    input  logic [gdb_pkg::MON_W-1:0]      i_end_month,
    input  logic [gdb_pkg::DAY_W-1:0]      i_end_day,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gdb_pkg::COUNT_W-1:0]    o_day_count,
    output logic                           o_order_error
);
    import gdb_pkg::*;

    logic     r_v1, r_v2, r_v3, r_v4, r_v5;
    logic     rdy1, rdy2, rdy3, rdy4, rdy5;
    t_pipe_en en;

    assign rdy5 = !r_v5 || !i_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    logic [SER_W-1:0] ser_a, ser_b;

    gdb_serial u_ser_start (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_year   (i_start_year),
        .i_month  (i_start_month),
        .i_day    (i_start_day),
        .o_serial (ser_a)
    );

    gdb_serial u_ser_end (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_year   (i_end_year),
        .i_month  (i_end_month),
        .i_day    (i_end_day),
        .o_serial (ser_b)
    );

    // stage 5: difference, order check, saturation
    logic [SER_W:0]     diff;
    logic               n_err;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_count;
    logic               r_err;

    assign diff  = {1'b0, ser_b} - {1'b0, ser_a};
    assign n_err = diff[SER_W];

    always_comb begin
        priority if (n_err) begin
            n_count = '0;
        end else if (diff[SER_W-1:COUNT_W] != '0) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_stall       = !rdy1;
    assign o_valid       = r_v5;
    assign o_day_count   = r_count;
    assign o_order_error = r_err;

endmodule

### sv/gdb_serial.sv
// ----------------------------------------------------------------------------
// gdb_serial
// Four-stage pipeline mapping one date to a serial day number.
// ----------------------------------------------------------------------------
module gdb_serial (
    input  logic                          i_clk,
    input  gdb_pkg::t_pipe_en             i_en,
    input  logic [gdb_pkg::YEAR_W-1:0]    i_year,
    input  logic [gdb_pkg::MON_W-1:0]     i_month,
    input  logic [gdb_pkg::DAY_W-1:0]     i_day,
    output logic [gdb_pkg::SER_W-1:0]     o_serial
);
    import gdb_pkg::*;

    // stage 1: year / 100 by reciprocal, month clamp
    logic [PROD_W-1:0] prod;
    logic [MON_W-1:0]  mon_c;
    logic [YEAR_W-1:0] r1_year;
    logic [QCEN_W-1:0] r1_q;
    logic [MON_W-1:0]  r1_mon;
    logic [DAY_W-1:0]  r1_day;

    assign prod = PROD_W'(i_year) * RECIP_100;

    always_comb begin
        priority if (i_month < MON_JAN) begin
            mon_c = MON_JAN;
        end else if (i_month > MON_DEC) begin
            mon_c = MON_DEC;
        end else begin
            mon_c = i_month;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_year <= i_year;
            r1_q    <= prod[RECIP_SHIFT +: QCEN_W];
            r1_mon  <= mon_c;
            r1_day  <= i_day;
        end
    end

    // stage 2: remainder, leap flag, century terms, 365*year
    logic [YEAR_W-1:0] q_x100;
    logic [YEAR_W-1:0] rem;
    logic              rem_nz;
    logic [YEAR_W:0]   prev;
    logic              n_leap;
    logic [QCEN_W-1:0] n_c;
    logic [SER_W-1:0]  r2_y365;
    logic [YEAR_W-2:0] r2_prev4;
    logic [QCEN_W-1:0] r2_c;
    logic              r2_leap;
    logic [MON_W-1:0]  r2_mon;
    logic [DAY_W-1:0]  r2_day;

    assign q_x100 = YEAR_W'(r1_q) * HUNDRED;
    assign rem    = r1_year - q_x100;
    assign rem_nz = (rem != '0);
    assign prev   = (YEAR_W+1)'(r1_year) + YEAR_OFS;
    assign n_leap = (r1_year[1:0] == 2'b00) && (rem_nz || (r1_q[1:0] == 2'b00));
    assign n_c    = r1_q + CENT_OFS + QCEN_W'(rem_nz);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_y365  <= SER_W'(r1_year) * DAYS_YEAR;
            r2_prev4 <= prev[YEAR_W:2];
            r2_c     <= n_c;
            r2_leap  <= n_leap;
            r2_mon   <= r1_mon;
            r2_day   <= r1_day;
        end
    end

    // stage 3: year part and in-year offset
    logic [SER_W-1:0] r3_base;
    logic [OFS_W-1:0] r3_ofs;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_base <= r2_y365 + SER_W'(r2_prev4) - SER_W'(r2_c)
                       + SER_W'(r2_c[QCEN_W-1:2]);
            r3_ofs  <= days_before(r2_mon) + OFS_W'(r2_leap && (r2_mon > MON_FEB))
                       + OFS_W'(r2_day);
        end
    end

    // stage 4: serial day number
    logic [SER_W-1:0] r4_serial;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_serial <= r3_base + SER_W'(r3_ofs);
        end
    end

    assign o_serial = r4_serial;

endmodule

### sv/gdb_checker.sv
// ----------------------------------------------------------------------------
// gdb_checker
// Port-level checks for the date difference core, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_days_between_core_defines.svh"

module gdb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_stall,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [gdb_pkg::COUNT_W-1:0]    o_day_count,
    input  logic                           o_order_error
);
    import gdb_pkg::*;

    // an out-of-order pair reports a zero count
    `GDB_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_order_error, o_day_count == '0)

    // a held result stays put
    `GDB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_day_count) && $stable(o_order_error))

    // back-pressure only comes from a full output
    `GDB_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_valid, !o_stall)

    // an open sink never back-pressures the source
    `GDB_ASSERT_NOW(a_stall_sink, i_clk, i_rst_n, !i_stall, !o_stall)

endmodule

bind gregorian_days_between_core gdb_checker u_gdb_checker (.*);

### tb/gregorian_days_between_core_checker.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_core_checker
// Watches both channels of the date difference core, predicts the day count
// and order flag of every accepted request and compares them, in order, with
// the results that the core hands out.
// ----------------------------------------------------------------------------
module gregorian_days_between_core_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_stall,
    input  logic [gdb_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [gdb_pkg::MON_W-1:0]      i_start_month,
    input  logic [gdb_pkg::DAY_W-1:0]      i_start_day,
    input  logic [gdb_pkg::YEAR_W-1:0]     i_end_year,
    input  logic [gdb_pkg::MON_W-1:0]      i_end_month,
    input  logic [gdb_pkg::DAY_W-1:0]      i_end_day,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_stall,
    input  logic [gdb_pkg::COUNT_W-1:0]    i_day_count,
    input  logic                           i_order_error,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SPAN_CAP = (1 << gdb_pkg::COUNT_W) - 1;
    localparam int unsigned MONTH_START [13] =
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct {
        logic [gdb_pkg::COUNT_W-1:0] day_count;
        logic                        order_error;
    } t_span;

    t_span span_q[$];
    int    fails = 0;
    int    open_spans = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = open_spans;

    // day number of a date; month clamped to 1..12, day used as a plain offset
    function automatic int unsigned date_serial(int unsigned y, int unsigned m,
                                                int unsigned d);
        int unsigned mm;
        int unsigned shifted;
        bit          leap;
        mm      = (m < 1) ? 1 : ((m > 12) ? 12 : m);
        shifted = y + 399;
        leap    = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        return 365 * y + shifted / 4 - shifted / 100 + shifted / 400
               + MONTH_START[mm] + ((mm > 2 && leap) ? 1 : 0) + d;
    endfunction

    function automatic t_span predict_span();
        int unsigned from_day;
        int unsigned to_day;
        t_span       r;
        from_day = date_serial(i_start_year, i_start_month, i_start_day);
        to_day   = date_serial(i_end_year, i_end_month, i_end_day);
        r.order_error = (from_day > to_day);
        if (from_day > to_day) begin
            r.day_count = '0;
        end else if (to_day - from_day > SPAN_CAP) begin
            r.day_count = gdb_pkg::COUNT_W'(SPAN_CAP);
        end else begin
            r.day_count = gdb_pkg::COUNT_W'(to_day - from_day);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_span want;
        int    bad;
        bad = 0;
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (span_q.size() == 0) begin
                    $error("result with no request pending: day_count %0d order_error %0b",
                           i_day_count, i_order_error);
                    bad++;
                end else begin
                    want = span_q.pop_front();
                    if (i_day_count !== want.day_count) begin
                        $error("day_count: expected %0d, got %0d", want.day_count, i_day_count);
                        bad++;
                    end
                    if (i_order_error !== want.order_error) begin
                        $error("order_error: expected %0b, got %0b",
                               want.order_error, i_order_error);
                        bad++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                span_q.push_back(predict_span());
            end
        end
        fails      <= fails + bad;
        open_spans <= span_q.size();
    end

endmodule

### tb/gregorian_days_between_core_test.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_core_test
// Drives date pairs into the date difference core: directed calendar corners
// (leap rules, ordering, clamped months, odd days, saturation) and then mostly
// well-formed random pairs with some raw noise, under random idling on both
// sides and one long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module gregorian_days_between_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 400;
    localparam int TAIL_REQS   = 60;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN       = 20;

    typedef struct packed {
        logic [gdb_pkg::YEAR_W-1:0] y;
        logic [gdb_pkg::MON_W-1:0]  m;
        logic [gdb_pkg::DAY_W-1:0]  d;
    } t_date;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [gdb_pkg::YEAR_W-1:0]  i_start_year;
    logic [gdb_pkg::MON_W-1:0]   i_start_month;
    logic [gdb_pkg::DAY_W-1:0]   i_start_day;
    logic [gdb_pkg::YEAR_W-1:0]  i_end_year;
    logic [gdb_pkg::MON_W-1:0]   i_end_month;
    logic [gdb_pkg::DAY_W-1:0]   i_end_day;
    logic                        o_valid;
    logic                        i_stall;
    logic [gdb_pkg::COUNT_W-1:0] o_day_count;
    logic                        o_order_error;

    int fail_count;
    int outstanding;
    bit tail = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    always #5 i_clk = ~i_clk;

    gregorian_days_between_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_end_year    (i_end_year),
        .i_end_month   (i_end_month),
        .i_end_day     (i_end_day),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_day_count   (o_day_count),
        .o_order_error (o_order_error)
    );

    gregorian_days_between_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_end_year    (i_end_year),
        .i_end_month   (i_end_month),
        .i_end_day     (i_end_day),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_day_count   (o_day_count),
        .i_order_error (o_order_error),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    function automatic t_date mk(int y, int m, int d);
        t_date r;
        r.y = gdb_pkg::YEAR_W'(y);
        r.m = gdb_pkg::MON_W'(m);
        r.d = gdb_pkg::DAY_W'(d);
        return r;
    endfunction

    function automatic int month_length(int y, int m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic int pick_year();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 100;
            2:       return 400;
            3:       return 1900;
            4:       return 2000;
            5:       return 9999;
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    function automatic t_date calendar_date(int y);
        int m;
        m = $urandom_range(1, 12);
        return mk(y, m, $urandom_range(1, month_length(y, m)));
    endfunction

    function automatic t_date raw_date();
        return mk($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    endfunction

    task automatic offer(t_date a, t_date b, bit may_idle);
        if (may_idle && !tail && !hold_req && hold_left == 0 && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_start_year  <= a.y;
        i_start_month <= a.m;
        i_start_day   <= a.d;
        i_end_year    <= b.y;
        i_end_month   <= b.m;
        i_end_day     <= b.d;
        do @(posedge i_clk); while (o_stall);
    endtask

    // output side: random stall bursts, calm stretches, one long hold-off
    initial begin
        int burst_left;
        int calm_left;
        burst_left = 0;
        calm_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (tail) begin
                i_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
                case ($urandom_range(0, 29))
                    0:          calm_left = $urandom_range(20, 60);
                    1, 2, 3, 4: burst_left = $urandom_range(1, 11);
                    default:    ;
                endcase
            end
        end
    end

    initial begin
        t_date a;
        t_date b;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_start_year  <= '0;
        i_start_month <= '0;
        i_start_day   <= '0;
        i_end_year    <= '0;
        i_end_month   <= '0;
        i_end_day     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(mk(2000, 1, 1),     mk(2000, 1, 1),     1'b0);
        offer(mk(0, 1, 1),        mk(9999, 12, 31),   1'b0);
        offer(mk(9999, 12, 31),   mk(0, 1, 1),        1'b0);
        offer(mk(2000, 2, 28),    mk(2000, 3, 1),     1'b0);
        offer(mk(1900, 2, 28),    mk(1900, 3, 1),     1'b0);
        offer(mk(2004, 2, 28),    mk(2004, 3, 1),     1'b0);
        offer(mk(2003, 2, 28),    mk(2003, 3, 1),     1'b0);
        offer(mk(0, 2, 28),       mk(0, 3, 1),        1'b0);
        offer(mk(1999, 12, 31),   mk(2000, 1, 1),     1'b0);
        offer(mk(2020, 5, 10),    mk(2020, 5, 9),     1'b0);
        offer(mk(2020, 6, 1),     mk(2020, 5, 31),    1'b0);
        offer(mk(2021, 1, 1),     mk(2020, 12, 31),   1'b0);
        // month 0 acts as January, months above 12 as December
        offer(mk(2021, 0, 5),     mk(2021, 1, 5),     1'b0);
        offer(mk(2021, 15, 1),    mk(2021, 12, 1),    1'b0);
        offer(mk(2021, 13, 9),    mk(2021, 14, 10),   1'b0);
        // day 0 and days past month end
        offer(mk(2021, 3, 0),     mk(2021, 2, 28),    1'b0);
        offer(mk(2021, 2, 31),    mk(2021, 3, 3),     1'b0);
        offer(mk(2024, 2, 30),    mk(2024, 3, 1),     1'b0);
        // years past 9999, saturation, all-ones and all-zero fields
        offer(mk(10000, 2, 28),   mk(10000, 3, 1),    1'b0);
        offer(mk(0, 0, 0),        mk(16383, 15, 31),  1'b0);
        offer(mk(16383, 15, 31),  mk(0, 0, 0),        1'b0);
        offer(mk(16383, 15, 31),  mk(16383, 15, 31),  1'b0);
        offer(mk(0, 0, 0),        mk(0, 0, 0),        1'b0);
        offer(mk(5000, 6, 15),    mk(16383, 12, 31),  1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == RANDOM_REQS - TAIL_REQS) tail = 1'b1;
            case ($urandom_range(0, 19))
                0, 1: begin
                    a = raw_date();
                    b = raw_date();
                end
                2, 3: begin
                    a = calendar_date(pick_year());
                    b = a;
                end
                4, 5, 6, 7, 8: begin
                    a = calendar_date(pick_year());
                    b = calendar_date((a.y >= 9999) ? 9999 : a.y + $urandom_range(0, 1));
                end
                9, 10, 11, 12, 13: begin
                    a = calendar_date(pick_year());
                    b = calendar_date(pick_year());
                    if (a > b) begin
                        {a, b} = {b, a};
                    end
                end
                default: begin
                    a = calendar_date(pick_year());
                    b = calendar_date(pick_year());
                end
            endcase
            offer(a, b, 1'b1);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
